/* rtl/qtg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qtg_pkg;

	// Graph size: VERTICES real vertices plus one virtual root
	localparam int VERTICES = 31;
	localparam int TOTAL    = VERTICES + 1;
	localparam int ROOT     = VERTICES;
	localparam int IDX_W    = $clog2(TOTAL);
	localparam int DEG_W    = $clog2(TOTAL + 1);
	localparam int PAR_W    = IDX_W + 1;
	localparam int GRP      = 8;
	localparam int NGRP     = (TOTAL + GRP - 1) / GRP;

	// Operation codes of an input item
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_RUN   = 2'd2
	} op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEG,
		ST_SCAN,
		ST_EMIT,
		ST_FAIL
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear;
		logic add;
		logic run_init;
		logic deg_step;
		logic scan_step;
		logic emit_ok;
		logic emit_fail;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic idx_last;
		logic deg_zero;
		logic fail;
		logic out_space;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/qtg_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module qtg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    op,
	input  wire qtg_pkg::sts_t sts,
	output qtg_pkg::cmd_t      cmd
);
	import qtg_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	assign accept = in_valid && !in_stall;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_RUN) begin
					state_nx = ST_DEG;
				end
			end
			ST_DEG: begin
				if (sts.idx_last) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.fail) begin
					state_nx = ST_FAIL;
				end else if (sts.idx_last && sts.deg_zero) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_space && sts.idx_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_FAIL: begin
				if (sts.out_space) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Outputs; idle never stalls, so a valid item is taken at once
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (op)
						OP_CLEAR: cmd.clear    = 1'b1;
						OP_ADD:   cmd.add      = 1'b1;
						OP_RUN:   cmd.run_init = 1'b1;
						default:  cmd          = '0;
					endcase
				end
			end
			ST_DEG:  cmd.deg_step  = 1'b1;
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_EMIT: cmd.emit_ok   = sts.out_space;
			ST_FAIL: cmd.emit_fail = sts.out_space;
			default: cmd           = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_run_starts_deg: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_RUN) |=> (state_q == ST_DEG))
		else $error("run item did not start degree pass");
	a_fail_reported: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.fail) |=> (state_q == ST_FAIL))
		else $error("scan failure not reported");
	a_emit_has_space: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_ok || cmd.emit_fail) |-> sts.out_space)
		else $error("result loaded into full output register");
`endif

endmodule

`default_nettype wire

/* rtl/qtg_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module qtg_dpath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire qtg_pkg::cmd_t               cmd,
	output qtg_pkg::sts_t                    sts,
	input  wire logic [4:0]                  vertex_a,
	input  wire logic [4:0]                  vertex_b,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [4:0]                       node,
	output logic signed [5:0]                parent,
	output logic                             ok,
	output logic                             last
);
	import qtg_pkg::*;

	// Graph and run state
	logic [VERTICES-1:0]     adj_q [VERTICES];
	logic signed [PAR_W-1:0] par_q [TOTAL];
	logic [IDX_W-1:0]        deg_of_q [TOTAL];
	logic [TOTAL-1:0]        vis_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        deg_q;

	// Output register
	logic                    out_valid_q;
	logic [IDX_W-1:0]        node_q;
	logic signed [PAR_W-1:0] parent_q;
	logic                    ok_q;
	logic                    last_q;

	logic [TOTAL-1:0]        row;
	logic [DEG_W-1:0]        grp_cnt [NGRP];
	logic [DEG_W-1:0]        row_cnt;
	logic signed [PAR_W-1:0] cur_par;
	logic                    match;
	logic [TOTAL-1:0]        upd;
	logic [TOTAL-1:0]        bad;
	logic                    idx_last;
	logic                    edge_ok;

	assign idx_last = (idx_q == IDX_W'(TOTAL - 1));
	assign edge_ok  = (vertex_a < 5'(VERTICES)) && (vertex_b < 5'(VERTICES))
		&& (vertex_a != vertex_b);

	// Select the current row; the root joins every real vertex
	always_comb begin
		if (idx_q == IDX_W'(ROOT)) begin
			row = {1'b0, {VERTICES{1'b1}}};
		end else begin
			row = {1'b1, adj_q[idx_q]};
		end
	end

	// Count row bits, eight at a time per group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_cnt[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < TOTAL) begin
					grp_cnt[g] = grp_cnt[g] + DEG_W'(row[g * GRP + j]);
				end
			end
		end
		row_cnt = '0;
		for (int g = 0; g < NGRP; g++) begin
			row_cnt = row_cnt + grp_cnt[g];
		end
	end

	// Check every unvisited neighbor against the current vertex's parent
	always_comb begin
		cur_par = par_q[idx_q];
		match   = (deg_of_q[idx_q] == deg_q);
		for (int k = 0; k < TOTAL; k++) begin
			upd[k] = row[k] && !vis_q[k];
			bad[k] = upd[k] && (par_q[k] != cur_par);
		end
	end

	assign sts.idx_last  = idx_last;
	assign sts.deg_zero  = (deg_q == '0);
	assign sts.fail      = cmd.scan_step && match && (|bad);
	assign sts.out_space = !out_valid_q || !out_stall;

	// Update matrix, parents, visited set and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < VERTICES; r++) begin
				adj_q[r] <= '0;
			end
			for (int r = 0; r < TOTAL; r++) begin
				par_q[r] <= '1;
			end
			vis_q <= '0;
			idx_q <= '0;
			deg_q <= '0;
		end else begin
			if (cmd.clear) begin
				for (int r = 0; r < VERTICES; r++) begin
					adj_q[r] <= '0;
				end
			end
			if (cmd.add && edge_ok) begin
				adj_q[vertex_a][vertex_b] <= 1'b1;
				adj_q[vertex_b][vertex_a] <= 1'b1;
			end
			if (cmd.run_init) begin
				for (int r = 0; r < TOTAL; r++) begin
					par_q[r] <= '1;
				end
				vis_q <= '0;
				idx_q <= '0;
				deg_q <= IDX_W'(TOTAL - 1);
			end
			if (cmd.deg_step) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			if (cmd.scan_step) begin
				if (match) begin
					vis_q[idx_q] <= 1'b1;
					for (int k = 0; k < TOTAL; k++) begin
						if (upd[k]) begin
							par_q[k] <= {1'b0, idx_q};
						end
					end
				end
				if (idx_last) begin
					idx_q <= '0;
					deg_q <= deg_q - 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.emit_ok) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	// Store degrees
	always_ff @(posedge clk) begin
		if (cmd.deg_step) begin
			deg_of_q[idx_q] <= row_cnt[IDX_W-1:0];
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ok || cmd.emit_fail) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_fail) begin
			node_q   <= '0;
			parent_q <= '1;
			ok_q     <= 1'b0;
			last_q   <= 1'b1;
		end else if (cmd.emit_ok) begin
			node_q   <= idx_q;
			parent_q <= par_q[idx_q];
			ok_q     <= 1'b1;
			last_q   <= idx_last;
		end
	end

	assign out_valid = out_valid_q;
	assign node      = node_q;
	assign parent    = parent_q;
	assign ok        = ok_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_init_clears_visited: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run_init |=> (vis_q == '0))
		else $error("visited set not cleared at run start");
	a_visit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && match) |=> vis_q[$past(idx_q)])
		else $error("visited vertex not marked");
	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (last_q && node_q == '0))
		else $error("failure result malformed");
`endif

endmodule

`default_nettype wire

/* rtl/quasi_threshold_graph_recognizer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Clear and add edge items produce no result.
// A run does degree counting (one matrix row a cycle), then an ordered scan
// (one degree/vertex pair a cycle), then emits one result per vertex, root included.
// A failure ends the scan early with one result.
// Output register holds a result while the next item is accepted.
// arst_n clears the matrix, parents, visited set, controller and output valid.
module quasi_threshold_graph_recognizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [4:0]  vertex_a,
	input  wire logic [4:0]  vertex_b,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       node,
	output logic signed [5:0] parent,
	output logic             ok,
	output logic             last
);
	import qtg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence the run
	qtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the graph and do the tree build
	qtg_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.vertex_a  (vertex_a),
		.vertex_b  (vertex_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.node      (node),
		.parent    (parent),
		.ok        (ok),
		.last      (last)
	);

endmodule

`default_nettype wire
